@@ rtl/core/pptm_pkg.sv @@
// pptm_pkg: shared constants, action codes and types for the process page table manager
// used by all modules in rtl/core
package pptm_pkg;
	localparam int MaxPages     = 64;
	localparam int MaxPageWords = 256;

	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_SEARCH = 3'd1;
	localparam logic [2:0] ACT_WRITE  = 3'd2;
	localparam logic [2:0] ACT_READ   = 3'd3;
	localparam logic [2:0] ACT_DELETE = 3'd4;

	localparam logic REG_PAGE_COUNT = 1'b0;
	localparam logic REG_PAGE_WORDS = 1'b1;

	// request from the sequencer to the modulo unit
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
	} pptm_mod_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] remainder;
	} pptm_mod_rsp_t;
endpackage

@@ rtl/core/pptm_mod.sv @@
// pptm_mod: restoring remainder unit, one quotient bit per cycle
// depends on pptm_pkg
module pptm_mod
	import pptm_pkg::*;
#(
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pptm_mod_req_t req,
	input  logic [DW-1:0] divisor,
	output pptm_mod_rsp_t rsp
);
	logic [31:0] rem_q;
	logic [31:0] num_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] dext;

	assign dext  = {{(33-DW){1'b0}}, divisor};
	assign trial = {rem_q, num_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			num_q <= req.dividend;
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			if (trial >= dext) rem_q <= 32'(trial - dext);
			else rem_q <= trial[31:0];
		end
	end

	assign rsp = '{done: done_q, remainder: rem_q};
endmodule

@@ rtl/core/pptm_seq.sv @@
// pptm_seq: sequencer, table scan, free stack and page memory
// depends on pptm_pkg and drives pptm_mod through a request struct
module pptm_seq
	import pptm_pkg::*;
#(
	parameter int MAX_PAGES      = MaxPages,
	parameter int MAX_PAGE_WORDS = MaxPageWords,
	localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
	localparam int CW = $clog2(MAX_PAGES + 1),
	localparam int OW = (MAX_PAGE_WORDS > 1) ? $clog2(MAX_PAGE_WORDS) : 1,
	localparam int WW = $clog2(MAX_PAGE_WORDS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    action,
	input  logic [31:0]   process_id,
	input  logic [15:0]   word_offset,
	input  logic [31:0]   write_value,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          success,
	output logic [5:0]    bucket,
	output logic [5:0]    page_number,
	output logic [31:0]   read_value,
	output pptm_mod_req_t mreq,
	input  pptm_mod_rsp_t mrsp,
	output logic [CW-1:0] page_count_q
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_EXEC  = 3'd3;
	localparam logic [2:0] ST_MEM   = 3'd4;
	localparam logic [2:0] ST_MOD   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]    state_q;
	logic [WW-1:0] page_words_q;
	logic [CW-1:0] top_q;
	logic [CW-1:0] live_q;
	logic [MAX_PAGES-1:0] valid_q;
	logic [31:0]   id_mem [MAX_PAGES];
	logic [PW-1:0] pg_mem [MAX_PAGES];
	logic [PW-1:0] stk_mem [MAX_PAGES];
	logic [31:0]   page_mem [2**(PW+OW)];
	logic [CW-1:0] idx_q;
	logic [CW-1:0] clr_q;
	logic [2:0]    act_q;
	logic [31:0]   pid_q;
	logic [15:0]   off_q;
	logic [31:0]   wval_q;
	logic          hit_q;
	logic [PW-1:0] hit_slot_q;
	logic          free_q;
	logic [PW-1:0] free_slot_q;
	logic [31:0]   id_rd_q;
	logic          rd_ok_q;
	logic [PW-1:0] rd_slot_q;
	logic [PW-1:0] stk_rd_q;
	logic [PW-1:0] pg_rd_q;
	logic [31:0]   mem_rd_q;
	logic          ovalid_q;
	logic          osucc_q;
	logic [5:0]    obucket_q;
	logic [5:0]    opage_q;
	logic [31:0]   oread_q;
	logic          do_write;
	logic [PW-1:0] wr_slot;
	logic [PW-1:0] stk_addr;
	logic          stk_we;
	logic [PW-1:0] stk_wdata;
	logic          off_ok;
	logic [CW-1:0] pc_new;
	logic [WW-1:0] pw_new;
	logic [PW+OW-1:0] maddr;

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid && !ovalid_q;
	assign out_valid = ovalid_q;
	assign success   = osucc_q;
	assign bucket    = obucket_q;
	assign page_number = opage_q;
	assign read_value  = oread_q;

	assign off_ok = {16'd0, off_q} < {{(32-WW){1'b0}}, page_words_q};
	assign maddr  = {pg_rd_q, off_q[OW-1:0]};

	always_comb begin
		pc_new = CW'(MAX_PAGES);
		if (cfg_data[6:0] == 7'd0) pc_new = CW'(1);
		else if ({25'd0, cfg_data[6:0]} <= 32'(MAX_PAGES)) pc_new = CW'(cfg_data[6:0]);
		pw_new = WW'(MAX_PAGE_WORDS);
		if (cfg_data[8:0] == 9'd0) pw_new = WW'(1);
		else if ({23'd0, cfg_data[8:0]} <= 32'(MAX_PAGE_WORDS)) pw_new = WW'(cfg_data[8:0]);
	end

	// stack port: clear sweep, push on delete, else read at top-1
	always_comb begin
		stk_we    = 1'b0;
		stk_wdata = pg_rd_q;
		stk_addr  = PW'(top_q - CW'(1));
		if (state_q == ST_CLEAR) begin
			stk_we    = 1'b1;
			stk_addr  = clr_q[PW-1:0];
			stk_wdata = clr_q[PW-1:0];
		end else if (state_q == ST_EXEC && act_q == ACT_DELETE && hit_q
				&& top_q < CW'(MAX_PAGES)) begin
			stk_we   = 1'b1;
			stk_addr = top_q[PW-1:0];
		end
	end

	assign do_write = (state_q == ST_EXEC) && act_q == ACT_INSERT && !hit_q && free_q
		&& live_q < page_count_q && pid_q != 32'd0 && top_q != '0;
	assign wr_slot  = free_slot_q;

	always_ff @(posedge clk) begin
		id_rd_q <= id_mem[idx_q[PW-1:0]];
		pg_rd_q <= pg_mem[hit_slot_q];
		stk_rd_q <= stk_mem[stk_addr];
		if (stk_we) stk_mem[stk_addr] <= stk_wdata;
		if (do_write) begin
			id_mem[wr_slot] <= pid_q;
			pg_mem[wr_slot] <= stk_rd_q;
		end
		mem_rd_q <= page_mem[maddr];
		if (state_q == ST_MEM && act_q == ACT_WRITE && hit_q && off_ok)
			page_mem[maddr] <= wval_q;
		if (state_q == ST_IDLE && in_valid && in_ready) begin
			act_q  <= action;
			pid_q  <= process_id;
			off_q  <= word_offset;
			wval_q <= write_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			page_count_q <= CW'(MAX_PAGES);
			page_words_q <= WW'(MAX_PAGE_WORDS);
			top_q   <= CW'(MAX_PAGES);
			live_q  <= '0;
			valid_q <= '0;
			idx_q   <= '0;
			clr_q   <= '0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			rd_ok_q <= 1'b0;
			hit_slot_q  <= '0;
			free_slot_q <= '0;
			rd_slot_q   <= '0;
			ovalid_q  <= 1'b0;
			osucc_q   <= 1'b0;
			obucket_q <= '0;
			opage_q   <= '0;
			oread_q   <= '0;
			mreq      <= '0;
		end else begin
			mreq.start <= 1'b0;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(MAX_PAGES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == REG_PAGE_COUNT) begin
							page_count_q <= pc_new;
							top_q   <= pc_new;
							live_q  <= '0;
							valid_q <= '0;
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else begin
							page_words_q <= pw_new;
						end
					end else if (in_valid && !ovalid_q) begin
						idx_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						rd_ok_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// one entry read per cycle, compared in the cycle after its read
					rd_slot_q <= idx_q[PW-1:0];
					rd_ok_q   <= idx_q < CW'(MAX_PAGES);
					if (idx_q < CW'(MAX_PAGES)) idx_q <= idx_q + CW'(1);
					if (rd_ok_q) begin
						if (valid_q[rd_slot_q] && id_rd_q == pid_q && !hit_q) begin
							hit_q <= 1'b1;
							hit_slot_q <= rd_slot_q;
						end
						if (!valid_q[rd_slot_q] && !free_q) begin
							free_q <= 1'b1;
							free_slot_q <= rd_slot_q;
						end
					end else if (idx_q == CW'(MAX_PAGES)) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					osucc_q   <= 1'b0;
					obucket_q <= '0;
					opage_q   <= '0;
					oread_q   <= '0;
					state_q   <= ST_OUT;
					case (act_q)
						ACT_INSERT: begin
							if (do_write) begin
								top_q <= top_q - CW'(1);
								live_q <= live_q + CW'(1);
								valid_q[wr_slot] <= 1'b1;
								osucc_q <= 1'b1;
								opage_q <= 6'(stk_rd_q);
							end
						end
						ACT_SEARCH: begin
							osucc_q <= hit_q;
							if (hit_q) opage_q <= 6'(pg_rd_q);
							mreq.start    <= 1'b1;
							mreq.dividend <= pid_q;
							state_q <= ST_MOD;
						end
						ACT_WRITE, ACT_READ: begin
							if (hit_q && off_ok) begin
								osucc_q <= 1'b1;
								opage_q <= 6'(pg_rd_q);
							end
							state_q <= ST_MEM;
						end
						ACT_DELETE: begin
							if (hit_q) begin
								osucc_q <= 1'b1;
								opage_q <= 6'(pg_rd_q);
								valid_q[hit_slot_q] <= 1'b0;
								if (top_q < CW'(MAX_PAGES)) top_q <= top_q + CW'(1);
								if (live_q != '0) live_q <= live_q - CW'(1);
							end
						end
						default: begin
						end
					endcase
				end
				ST_MEM: state_q <= (act_q == ACT_READ) ? ST_MOD : ST_OUT;
				ST_MOD: begin
					if (act_q == ACT_READ) begin
						if (osucc_q) oread_q <= mem_rd_q;
						state_q <= ST_OUT;
					end else if (mrsp.done) begin
						obucket_q <= 6'(mrsp.remainder);
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					ovalid_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/process_page_table_manager.sv @@
// process page table manager: one word in flight; each input word runs a table scan,
// then an execute step; write and read add a page-memory step, read a read-back step,
// and search a remainder step, before the result word is made valid
// the next input word is taken only once the result word has been accepted
// reset, and any page_count write, run a clear pass that refills the
// free-page stack; neither configuration nor input words are taken meanwhile
module process_page_table_manager
	import pptm_pkg::*;
#(
	parameter int MAX_PAGES      = MaxPages,
	parameter int MAX_PAGE_WORDS = MaxPageWords
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // action, process_id, word_offset, write_value, pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // success, bucket, page_number, read_value, pad
);
	localparam int CW = $clog2(MAX_PAGES + 1);

	pptm_mod_req_t mreq;
	pptm_mod_rsp_t mrsp;
	logic [CW-1:0] page_count_q;
	logic          succ;
	logic [5:0]    bkt;
	logic [5:0]    pg;
	logic [31:0]   rv;

	pptm_seq #(.MAX_PAGES(MAX_PAGES), .MAX_PAGE_WORDS(MAX_PAGE_WORDS)) u_seq (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.action(s_tdata[2:0]), .process_id(s_tdata[34:3]),
		.word_offset(s_tdata[50:35]), .write_value(s_tdata[82:51]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.success(succ), .bucket(bkt), .page_number(pg), .read_value(rv),
		.mreq, .mrsp, .page_count_q
	);

	pptm_mod #(.DW(CW)) u_mod (
		.clk, .arst_n, .req(mreq), .divisor(page_count_q), .rsp(mrsp)
	);

	assign m_tdata = {3'd0, rv, pg, bkt, succ};
endmodule
